>>> rtl/core/polar_vector_add_top_defines.svh
// Assertion macros shared by the polar vector adder RTL.
`ifndef POLAR_VECTOR_ADD_TOP_DEFINES_SVH
`define POLAR_VECTOR_ADD_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/pva_pkg.sv
// Package with widths, constants and the arctangent table of the polar vector adder.
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;
    localparam int STEPS_DEF = 16;
    localparam int STEPS_MAX = 24;
    localparam int W_RADIUS  = 24;
    localparam int W_ANGLE   = 16;
    localparam int W_XY      = 26;
    localparam int W_RAD_OUT = 25;
    localparam int W_TURN    = 32;
    localparam int W_ROT     = 36;
    localparam int W_SUM     = 37;
    localparam int W_VEC     = 38;
    localparam int W_GAIN    = 32;

    localparam logic [63:0] KINF_Q32  = 64'd2608131496;
    localparam logic [63:0] KCORR_Q32 = 64'd1738754331;
    localparam logic [W_TURN-1:0] HALF_TURN = 32'h8000_0000;

    function automatic logic [W_GAIN-1:0] gain_q32(input int n);
        logic [63:0] g;
        g = KINF_Q32 + (KCORR_Q32 >> (2 * n));
        return g[W_GAIN-1:0];
    endfunction

    function automatic logic [W_TURN-1:0] atan_turn(input int i);
        logic [W_TURN-1:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            default: t = '0;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/pva_rot_lane.sv
// One rotation-mode CORDIC lane: polar vector to rectangular x and y.
`timescale 1ns / 1ps
`default_nettype none
module pva_rot_lane #(
    parameter int          STEPS = pva_pkg::STEPS_DEF,
    parameter logic [31:0] GAIN  = pva_pkg::gain_q32(pva_pkg::STEPS_DEF)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [pva_pkg::W_RADIUS-1:0]      i_radius,
    input  wire logic signed [pva_pkg::W_ANGLE-1:0] i_angle,
    output logic signed [pva_pkg::W_ROT-1:0]       o_x,
    output logic signed [pva_pkg::W_ROT-1:0]       o_y
);
    import pva_pkg::*;

    localparam int W_PROD = W_RADIUS + W_GAIN;

    logic [W_PROD-1:0]        r_prod;
    logic [W_TURN-1:0]        r_za;
    logic signed [W_ROT-1:0]  r_x [0:STEPS];
    logic signed [W_ROT-1:0]  r_y [0:STEPS];
    logic [W_TURN-1:0]        r_z [0:STEPS];
    logic signed [W_ROT-1:0]  n_x0;
    logic [W_TURN-1:0]        n_z0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= W_PROD'(i_radius) * W_PROD'(GAIN);
            r_za   <= {i_angle, 16'b0};
        end
    end

    // Angles in the second and third quadrant start from the negated radius.
    always_comb begin
        n_x0 = W_ROT'(r_prod[W_PROD-1:24]);
        n_z0 = r_za;
        if (r_za[W_TURN-1] != r_za[W_TURN-2]) begin
            n_x0 = -n_x0;
            n_z0 = r_za + HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[k][W_TURN-1]) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_turn(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_turn(k);
                end
            end
        end
    end

    assign o_x = r_x[STEPS];
    assign o_y = r_y[STEPS];
endmodule
`default_nettype wire

>>> rtl/core/pva_vec_pipe.sv
// Merge of the two lanes and vectoring-mode CORDIC back to radius and angle.
`timescale 1ns / 1ps
`default_nettype none
module pva_vec_pipe #(
    parameter int          STEPS = pva_pkg::STEPS_DEF,
    parameter logic [31:0] GAIN  = pva_pkg::gain_q32(pva_pkg::STEPS_DEF)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [pva_pkg::W_ROT-1:0]   i_x1,
    input  wire logic signed [pva_pkg::W_ROT-1:0]   i_y1,
    input  wire logic signed [pva_pkg::W_ROT-1:0]   i_x2,
    input  wire logic signed [pva_pkg::W_ROT-1:0]   i_y2,
    output logic signed [pva_pkg::W_XY-1:0]         o_sum_x,
    output logic signed [pva_pkg::W_XY-1:0]         o_sum_y,
    output logic [pva_pkg::W_RAD_OUT-1:0]           o_sum_radius,
    output logic signed [pva_pkg::W_ANGLE-1:0]      o_sum_angle
);
    import pva_pkg::*;

    localparam int W_MAG = W_VEC - 1;
    localparam int W_PP  = W_MAG + 16;
    localparam logic signed [W_SUM-1:0] XY_MAX = W_SUM'(2**(W_XY-1) - 1);
    localparam logic signed [W_SUM-1:0] XY_MIN = -W_SUM'(2**(W_XY-1));

    logic signed [W_SUM-1:0] r_sx;
    logic signed [W_SUM-1:0] r_sy;
    logic signed [W_VEC-1:0] r_vx [0:STEPS];
    logic signed [W_VEC-1:0] r_vy [0:STEPS];
    logic [W_TURN-1:0]       r_vz [0:STEPS];
    logic signed [W_XY-1:0]  r_ox [0:STEPS];
    logic signed [W_XY-1:0]  r_oy [0:STEPS];
    logic                    r_zero [0:STEPS];
    logic [W_PP-1:0]         r_pa;
    logic [W_PP-1:0]         r_pb;
    logic [W_TURN-1:0]       r_mz;
    logic signed [W_XY-1:0]  r_mx;
    logic signed [W_XY-1:0]  r_my;
    logic                    r_mzero;

    logic signed [W_SUM-1:0] n_rx;
    logic signed [W_SUM-1:0] n_ry;
    logic signed [W_XY-1:0]  n_ox;
    logic signed [W_XY-1:0]  n_oy;
    logic [W_MAG-1:0]        n_mag;
    logic [W_PP:0]           n_acc;
    logic [W_PP-16:0]        n_prod;
    logic [W_PP-15:0]        n_rnd;
    logic [W_TURN-1:0]       n_ang;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= W_SUM'(i_x1) + W_SUM'(i_x2);
            r_sy <= W_SUM'(i_y1) + W_SUM'(i_y2);
        end
    end

    // Round off 8 fraction bits, back to the scale of the input radius, then saturate to the port width.
    always_comb begin
        n_rx = (r_sx + W_SUM'(128)) >>> 8;
        n_ry = (r_sy + W_SUM'(128)) >>> 8;
        if (n_rx > XY_MAX) begin
            n_ox = XY_MAX[W_XY-1:0];
        end else if (n_rx < XY_MIN) begin
            n_ox = XY_MIN[W_XY-1:0];
        end else begin
            n_ox = n_rx[W_XY-1:0];
        end
        if (n_ry > XY_MAX) begin
            n_oy = XY_MAX[W_XY-1:0];
        end else if (n_ry < XY_MIN) begin
            n_oy = XY_MIN[W_XY-1:0];
        end else begin
            n_oy = n_ry[W_XY-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox[0]   <= n_ox;
            r_oy[0]   <= n_oy;
            r_zero[0] <= (r_sx == '0) && (r_sy == '0);
            if (r_sx[W_SUM-1]) begin
                r_vx[0] <= -W_VEC'(r_sx);
                r_vy[0] <= -W_VEC'(r_sy);
                r_vz[0] <= HALF_TURN;
            end else begin
                r_vx[0] <= W_VEC'(r_sx);
                r_vy[0] <= W_VEC'(r_sy);
                r_vz[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ox[k+1]   <= r_ox[k];
                r_oy[k+1]   <= r_oy[k];
                r_zero[k+1] <= r_zero[k];
                if (!r_vy[k][W_VEC-1]) begin
                    r_vx[k+1] <= r_vx[k] + (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] - (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] + atan_turn(k);
                end else begin
                    r_vx[k+1] <= r_vx[k] - (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] + (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] - atan_turn(k);
                end
            end
        end
    end

    // The gain product is split into two 16-bit halves of the gain.
    assign n_mag = (r_vx[STEPS] > 0) ? r_vx[STEPS][W_MAG-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa    <= W_PP'(n_mag) * W_PP'(GAIN[31:16]);
            r_pb    <= W_PP'(n_mag) * W_PP'(GAIN[15:0]);
            r_mz    <= r_vz[STEPS];
            r_mx    <= r_ox[STEPS];
            r_my    <= r_oy[STEPS];
            r_mzero <= r_zero[STEPS];
        end
    end

    always_comb begin
        n_acc  = {1'b0, r_pa} + (W_PP+1)'(r_pb[W_PP-1:16]);
        n_prod = n_acc[W_PP:16];
        n_rnd  = {1'b0, n_prod} + (W_PP-14)'(128);
        n_ang  = r_mz + W_TURN'(32'h8000);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum_x <= r_mx;
            o_sum_y <= r_my;
            if (r_mzero) begin
                o_sum_radius <= '0;
                o_sum_angle  <= '0;
            end else begin
                if (|n_rnd[W_PP-15:W_RAD_OUT+8]) begin
                    o_sum_radius <= '1;
                end else begin
                    o_sum_radius <= n_rnd[W_RAD_OUT+7:8];
                end
                o_sum_angle <= n_ang[W_TURN-1:16];
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/polar_vector_add_top.sv
// Throughput: one beat per cycle; the whole pipeline advances together and holds
// only while the output register is full and not taken.
// Two rotation lanes run side by side, one per input vector, then a vectoring CORDIC.
// Reset clears the stage valid bits only; no data state survives between beats.
`timescale 1ns / 1ps
`default_nettype none
module polar_vector_add_top #(
    parameter int CORDIC_STEPS = pva_pkg::STEPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [pva_pkg::W_RADIUS-1:0]       i_first_radius,
    input  wire logic signed [pva_pkg::W_ANGLE-1:0] i_first_angle,
    input  wire logic [pva_pkg::W_RADIUS-1:0]       i_second_radius,
    input  wire logic signed [pva_pkg::W_ANGLE-1:0] i_second_angle,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [pva_pkg::W_XY-1:0]         o_sum_x,
    output logic signed [pva_pkg::W_XY-1:0]         o_sum_y,
    output logic [pva_pkg::W_RAD_OUT-1:0]           o_sum_radius,
    output logic signed [pva_pkg::W_ANGLE-1:0]      o_sum_angle
);
    import pva_pkg::*;
`include "polar_vector_add_top_defines.svh"

    localparam int          N    = (CORDIC_STEPS > STEPS_MAX) ? STEPS_MAX : CORDIC_STEPS;
    localparam logic [31:0] GAIN = gain_q32(N);
    localparam int          LAT  = 2 * N + 6;

    logic [LAT-1:0]          r_valid;
    logic                    adv;
    logic signed [W_ROT-1:0] x1;
    logic signed [W_ROT-1:0] y1;
    logic signed [W_ROT-1:0] x2;
    logic signed [W_ROT-1:0] y2;

    assign adv     = !r_valid[LAT-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {r_valid[LAT-2:0], i_valid};
        end
    end

    pva_rot_lane #(.STEPS(N), .GAIN(GAIN)) u_lane_first (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_radius (i_first_radius),
        .i_angle  (i_first_angle),
        .o_x      (x1),
        .o_y      (y1)
    );

    pva_rot_lane #(.STEPS(N), .GAIN(GAIN)) u_lane_second (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_radius (i_second_radius),
        .i_angle  (i_second_angle),
        .o_x      (x2),
        .o_y      (y2)
    );

    pva_vec_pipe #(.STEPS(N), .GAIN(GAIN)) u_vec (
        .i_clk        (i_clk),
        .i_en         (adv),
        .i_x1         (x1),
        .i_y1         (y1),
        .i_x2         (x2),
        .i_y2         (y2),
        .o_sum_x      (o_sum_x),
        .o_sum_y      (o_sum_y),
        .o_sum_radius (o_sum_radius),
        .o_sum_angle  (o_sum_angle)
    );

    `PVA_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !o_ready, o_valid, "stall without result")
    `PVA_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_valid[0], "beat lost")
    `PVA_ASSERT_NEXT(a_last_stage_lands, i_clk, i_rst_n, r_valid[LAT-2] && o_ready, o_valid, "result lost")
endmodule
`default_nettype wire
